### rtl/tlnf_pkg.sv
// Package for the text line-number formatter.
// Holds the character codes, register map, config and job flag types, and back-end phases.
// No dependencies.
package tlnf_pkg;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] WS_OFFSET = 8'h40;

  // Register map: word index taken from paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_NUMBER_LINES    = 2'd0;
  localparam logic [1:0] REG_MARK_LINE_ENDS  = 2'd1;
  localparam logic [1:0] REG_SHOW_WHITESPACE = 2'd2;

  typedef struct packed {
    logic number_lines;
    logic mark_line_ends;
    logic show_whitespace;
  } cfg_t;

  // What the back end must emit around one text byte
  typedef struct packed {
    logic prefix;
    logic dollar;
    logic caret;
  } job_flags_t;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_SP1,
    PH_SP2,
    PH_DOLLAR,
    PH_CARET,
    PH_BYTE
  } phase_e;

endpackage

### rtl/text_in_if.sv
// Stream interface for input text bytes.
// Carries valid, ready and one text byte; no dependencies.
interface text_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

### rtl/fmt_out_if.sv
// Stream interface for formatted output bytes.
// Carries valid, ready, the output byte and the end-of-run mark; no dependencies.
interface fmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/tlnf_queue.sv
// Small register FIFO between the formatter front and back ends.
// Generic width and depth; no package dependencies.
module tlnf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tlnf_front.sv
// Front end: accepts text bytes, classifies them and tracks the line count.
// Depends on tlnf_pkg and text_in_if; pushes one job per byte into the queue.
module tlnf_front #(
  parameter int unsigned COUNT_DIGITS = 6,
  parameter int unsigned DIG_W        = 3,
  parameter int unsigned JOB_W        = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlnf_pkg::cfg_t   cfg_i,
  text_in_if.sink          in_i,
  output logic             push_o,
  output logic [JOB_W-1:0] job_o,
  input  logic             push_ready_i
);
  import tlnf_pkg::*;

  localparam int unsigned CNT_W = 4 * COUNT_DIGITS;

  logic [CNT_W-1:0] count_q, count_d;
  logic             first_q, first_d;
  logic             pend_q, pend_d;
  logic [7:0]       c;
  logic             is_nl, is_ws, prefix;
  logic             accept;
  logic [DIG_W-1:0] start_idx;
  job_flags_t       flags;
  logic [7:0]       job_byte;

  // Saturating BCD increment
  function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    logic             sat;
    logic             carry;
    r     = v;
    sat   = 1'b1;
    carry = 1'b1;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if (v[4*k +: 4] != 4'd9) sat = 1'b0;
    end
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if (carry) begin
        if (v[4*k +: 4] >= 4'd9) begin
          r[4*k +: 4] = 4'd0;
        end else begin
          r[4*k +: 4] = v[4*k +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return sat ? v : r;
  endfunction

  assign c      = in_i.text_byte;
  assign accept = in_i.valid && push_ready_i;
  assign in_i.ready = push_ready_i;

  // Classification
  assign is_nl  = (c == CH_NL);
  assign is_ws  = is_nl || (c == CH_TAB) || (c == CH_SPACE);
  assign prefix = cfg_i.number_lines && (first_q || (!is_ws && pend_q));

  assign flags.prefix = prefix;
  assign flags.dollar = is_nl && cfg_i.mark_line_ends;
  assign flags.caret  = is_ws && cfg_i.show_whitespace;
  assign job_byte     = flags.caret ? c + WS_OFFSET : c;

  // Most significant nonzero digit of the count, digit zero if none
  always_comb begin
    start_idx = '0;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if (count_q[4*k +: 4] != 4'd0) start_idx = DIG_W'(k);
    end
  end

  assign push_o = accept;
  assign job_o  = {count_q, start_idx, flags, job_byte};

  // State update on each transfer
  always_comb begin
    count_d = count_q;
    first_d = first_q;
    pend_d  = pend_q;
    if (accept) begin
      first_d = 1'b0;
      if (prefix) count_d = bcd_inc(count_q);
      if (is_nl) begin
        pend_d = 1'b1;
      end else if (!is_ws && cfg_i.number_lines) begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
      first_q <= 1'b1;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      first_q <= first_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/tlnf_back.sv
// Back end: expands each queued job into output bytes, one per cycle while the output is not stalled.
// Depends on tlnf_pkg and fmt_out_if; drives an output register on the result stream.
module tlnf_back #(
  parameter int unsigned COUNT_DIGITS = 6,
  parameter int unsigned DIG_W        = 3,
  parameter int unsigned JOB_W        = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [JOB_W-1:0] q_data_i,
  output logic             pop_o,
  fmt_out_if.source        out_o
);
  import tlnf_pkg::*;

  localparam int unsigned CNT_W = 4 * COUNT_DIGITS;

  // Queue head fields
  logic [CNT_W-1:0] h_count;
  logic [DIG_W-1:0] h_start;
  job_flags_t       h_flags;
  logic [7:0]       h_byte;

  // Current job
  logic             cur_valid_q;
  logic [CNT_W-1:0] cur_count_q;
  logic [DIG_W-1:0] cur_start_q;
  job_flags_t       cur_flags_q;
  logic [7:0]       cur_byte_q;
  phase_e           phase_q, phase_d;
  logic [DIG_W-1:0] digit_q, digit_d;

  // Output register
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic             adv, emit, load, cur_last;
  logic [7:0]       cur_out;
  phase_e           init_phase;

  assign {h_count, h_start, h_flags, h_byte} = q_data_i;

  assign adv      = !out_valid_q || out_o.ready;
  assign emit     = cur_valid_q && adv;
  assign cur_last = (phase_q == PH_BYTE);
  assign load     = q_valid_i && (!cur_valid_q || (emit && cur_last));
  assign pop_o    = load;

  // First phase of a freshly loaded job
  always_comb begin
    if (h_flags.prefix) init_phase = PH_DIGIT;
    else if (h_flags.dollar) init_phase = PH_DOLLAR;
    else if (h_flags.caret) init_phase = PH_CARET;
    else init_phase = PH_BYTE;
  end

  // Current byte and next phase
  always_comb begin
    cur_out = cur_byte_q;
    phase_d = phase_q;
    digit_d = digit_q;
    case (phase_q)
      PH_DIGIT: begin
        cur_out = CH_ZERO + {4'b0000, cur_count_q[4*digit_q +: 4]};
        if (digit_q == '0) begin
          phase_d = PH_SP1;
        end else begin
          digit_d = digit_q - 1'b1;
        end
      end
      PH_SP1: begin
        cur_out = CH_SPACE;
        phase_d = PH_SP2;
      end
      PH_SP2: begin
        cur_out = CH_SPACE;
        if (cur_flags_q.dollar) phase_d = PH_DOLLAR;
        else if (cur_flags_q.caret) phase_d = PH_CARET;
        else phase_d = PH_BYTE;
      end
      PH_DOLLAR: begin
        cur_out = CH_DOLLAR;
        phase_d = cur_flags_q.caret ? PH_CARET : PH_BYTE;
      end
      PH_CARET: begin
        cur_out = CH_CARET;
        phase_d = PH_BYTE;
      end
      PH_BYTE: begin
        cur_out = cur_byte_q;
      end
      default: begin
        cur_out = cur_byte_q;
        phase_d = PH_BYTE;
      end
    endcase
  end

  // Job control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PH_BYTE;
      digit_q     <= '0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      phase_q     <= init_phase;
      digit_q     <= h_start;
    end else if (emit && cur_last) begin
      cur_valid_q <= 1'b0;
    end else if (emit) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
    end
  end

  // Job payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_count_q <= h_count;
      cur_start_q <= h_start;
      cur_flags_q <= h_flags;
      cur_byte_q  <= h_byte;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cur_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_out;
      out_last_q <= cur_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;

  // Digit phases belong to prefixed jobs only
  a_digit_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && (phase_q == PH_DIGIT) |-> cur_flags_q.prefix)
    else $error("digit phase without prefix");

  // Digit walk never starts above the leading digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && (phase_q == PH_DIGIT) |-> (digit_q <= cur_start_q))
    else $error("digit index above leading digit");

  // A pop only happens on a nonempty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // A loaded job shows up as valid on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cur_valid_q)
    else $error("loaded job not held");

endmodule

### rtl/text_line_number_formatter_top.sv
// Top level of the text line-number formatter: APB registers, front end, queue, back end.
// Depends on tlnf_pkg, text_in_if, fmt_out_if, tlnf_front, tlnf_queue and tlnf_back.
// Path: the queue, the current-job register and the output register lie between an input byte and its output.
// Throughput: one output byte per cycle from the back end while the output is not stalled; an input byte
// causes 1 to COUNT_DIGITS+5 output bytes, set by the back end's emit sequence.
// Reset: count is one, first-byte prefix pending, config cleared; data registers are not reset; no clearing pass.
module text_line_number_formatter_top #(
  parameter int unsigned COUNT_DIGITS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [tlnf_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  output logic [31:0]               prdata_o,
  output logic                      pready_o,
  text_in_if.sink                   in_i,
  fmt_out_if.source                 out_o
);
  import tlnf_pkg::*;

  localparam int unsigned DIG_W       = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
  localparam int unsigned JOB_W       = 4 * COUNT_DIGITS + DIG_W + $bits(job_flags_t) + 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t             cfg_q;
  logic [1:0]       reg_idx;
  logic             wr_en;
  logic             push, push_ready, pop, q_valid;
  logic [JOB_W-1:0] push_job, q_job;

  // Configuration registers
  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[3:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUMBER_LINES:    cfg_q.number_lines    <= pwdata_i[0];
        REG_MARK_LINE_ENDS:  cfg_q.mark_line_ends  <= pwdata_i[0];
        REG_SHOW_WHITESPACE: cfg_q.show_whitespace <= pwdata_i[0];
        default:             cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUMBER_LINES:    prdata_o = {31'b0, cfg_q.number_lines};
      REG_MARK_LINE_ENDS:  prdata_o = {31'b0, cfg_q.mark_line_ends};
      REG_SHOW_WHITESPACE: prdata_o = {31'b0, cfg_q.show_whitespace};
      default:             prdata_o = '0;
    endcase
  end

  tlnf_front #(
    .COUNT_DIGITS(COUNT_DIGITS),
    .DIG_W       (DIG_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .push_o      (push),
    .job_o       (push_job),
    .push_ready_i(push_ready)
  );

  tlnf_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_job)
  );

  tlnf_back #(
    .COUNT_DIGITS(COUNT_DIGITS),
    .DIG_W       (DIG_W),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_job),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

### tb/sv/text_line_number_formatter_checker.sv
// Scoreboard for the text line-number formatter: follows the APB register writes,
// predicts the formatted bytes for every accepted text byte and compares the output channel.
// Depends on tlnf_pkg, text_in_if and fmt_out_if.
module text_line_number_formatter_checker #(
  parameter int unsigned COUNT_DIGITS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [tlnf_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        pready_i,
  text_in_if                          text_mon,
  fmt_out_if                          fmt_mon,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 runs_done_o,
  output int unsigned                 pending_bytes_o
);
  import tlnf_pkg::*;

  localparam logic [4*COUNT_DIGITS-1:0] ALL_NINES = {COUNT_DIGITS{4'h9}};
  localparam logic [4*COUNT_DIGITS-1:0] BCD_ONE   = {{(4*COUNT_DIGITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } fmt_byte_t;

  // Shadow of the block's registers and line state
  cfg_t                      shadow_cfg;
  logic [4*COUNT_DIGITS-1:0] line_bcd;
  logic                      first_pending;
  logic                      number_pending;

  logic [7:0] run_bytes[$];
  fmt_byte_t  expected_out[$];

  // Decimal line number without leading zeros, two spaces, then count up unless all nines
  task automatic emit_line_number();
    logic [3:0] digit;
    bit         started;
    bit         carry;
    started = 1'b0;
    for (int k = COUNT_DIGITS - 1; k >= 0; k--) begin
      digit = line_bcd[4*k +: 4];
      if (digit != 4'd0 || started || k == 0) begin
        started = 1'b1;
        run_bytes.push_back(CH_ZERO + {4'h0, digit});
      end
    end
    run_bytes.push_back(CH_SPACE);
    run_bytes.push_back(CH_SPACE);
    if (line_bcd != ALL_NINES) begin
      carry = 1'b1;
      for (int k = 0; k < COUNT_DIGITS; k++) begin
        if (carry) begin
          digit = line_bcd[4*k +: 4];
          if (digit >= 4'd9) begin
            line_bcd[4*k +: 4] = 4'd0;
          end else begin
            line_bcd[4*k +: 4] = digit + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endtask

  // Expected output bytes for one text byte
  task automatic format_text_byte(input logic [7:0] c);
    run_bytes.delete();
    if (first_pending) begin
      first_pending = 1'b0;
      if (shadow_cfg.number_lines) emit_line_number();
    end
    if (c == CH_NL || c == CH_TAB || c == CH_SPACE) begin
      if (c == CH_NL) begin
        number_pending = 1'b1;
        if (shadow_cfg.mark_line_ends) run_bytes.push_back(CH_DOLLAR);
      end
      if (shadow_cfg.show_whitespace) begin
        run_bytes.push_back(CH_CARET);
        run_bytes.push_back(c + WS_OFFSET);
      end else begin
        run_bytes.push_back(c);
      end
    end else begin
      if (shadow_cfg.number_lines && number_pending) begin
        emit_line_number();
        number_pending = 1'b0;
      end
      run_bytes.push_back(c);
    end
    foreach (run_bytes[i]) begin
      expected_out.push_back('{out_byte: run_bytes[i],
                               last_of_run: (i == run_bytes.size() - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fmt_byte_t exp_byte;
    if (!rst_ni) begin
      shadow_cfg       = '0;
      line_bcd         = BCD_ONE;
      first_pending    = 1'b1;
      number_pending   = 1'b0;
      expected_out.delete();
      mismatch_count_o = 0;
      runs_done_o      = 0;
      pending_bytes_o  = 0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_NUMBER_LINES:    shadow_cfg.number_lines    = pwdata_i[0];
          REG_MARK_LINE_ENDS:  shadow_cfg.mark_line_ends  = pwdata_i[0];
          REG_SHOW_WHITESPACE: shadow_cfg.show_whitespace = pwdata_i[0];
          default: ;
        endcase
      end
      // text byte transfer
      if (text_mon.valid && text_mon.ready) format_text_byte(text_mon.text_byte);
      // output byte transfer against the oldest expectation
      if (fmt_mon.valid && fmt_mon.ready) begin
        if (expected_out.size() == 0) begin
          $error("out_byte: no transfer expected, actual %h (last_of_run %b)",
                 fmt_mon.out_byte, fmt_mon.last_of_run);
          mismatch_count_o++;
        end else begin
          exp_byte = expected_out.pop_front();
          if (fmt_mon.out_byte !== exp_byte.out_byte) begin
            $error("out_byte: expected %h, actual %h", exp_byte.out_byte, fmt_mon.out_byte);
            mismatch_count_o++;
          end
          if (fmt_mon.last_of_run !== exp_byte.last_of_run) begin
            $error("last_of_run: expected %b, actual %b",
                   exp_byte.last_of_run, fmt_mon.last_of_run);
            mismatch_count_o++;
          end
          if (exp_byte.last_of_run) runs_done_o++;
        end
      end
      pending_bytes_o = expected_out.size();
    end
  end

endmodule

### tb/sv/text_line_number_formatter_top_tb.sv
// Testbench top for the text line-number formatter: clock, reset, APB setup and text stimulus,
// random back pressure, stall watchdog and verdict.
// Depends on tlnf_pkg, text_in_if, fmt_out_if, the formatter top and its checker.
module text_line_number_formatter_top_tb;
  import tlnf_pkg::*;

  // Two digits keep count saturation reachable in a short run
  localparam int unsigned LINE_DIGITS = 2;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel_i;
  logic              penable_i;
  logic              pwrite_i;
  logic [ADDR_W-1:0] paddr_i;
  logic [31:0]       pwdata_i;
  logic [31:0]       prdata_o;
  logic              pready_o;

  text_in_if text_ch();
  fmt_out_if fmt_ch();

  int unsigned mismatch_count;
  int unsigned runs_done;
  int unsigned pending_bytes;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold_req = 1'b0;

  text_line_number_formatter_top #(
    .COUNT_DIGITS(LINE_DIGITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .in_i      (text_ch),
    .out_o     (fmt_ch)
  );

  text_line_number_formatter_checker #(
    .COUNT_DIGITS(LINE_DIGITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel_i),
    .penable_i        (penable_i),
    .pwrite_i         (pwrite_i),
    .paddr_i          (paddr_i),
    .pwdata_i         (pwdata_i),
    .pready_i         (pready_o),
    .text_mon         (text_ch),
    .fmt_mon          (fmt_ch),
    .mismatch_count_o (mismatch_count),
    .runs_done_o      (runs_done),
    .pending_bytes_o  (pending_bytes)
  );

  always #5 clk_i = ~clk_i;

  // Stall watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((text_ch.valid && text_ch.ready) || (fmt_ch.valid && fmt_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin
    fmt_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        fmt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        fmt_ch.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        fmt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        fmt_ch.ready <= 1'b1;
      end else begin
        fmt_ch.ready <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] reg_idx, input logic value);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {reg_idx, 2'b00};
    pwdata_i  <= {31'd0, value};
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // cfg order: {number_lines, mark_line_ends, show_whitespace}
  task automatic set_config(input logic [2:0] cfg);
    write_reg(REG_NUMBER_LINES, cfg[2]);
    write_reg(REG_MARK_LINE_ENDS, cfg[1]);
    write_reg(REG_SHOW_WHITESPACE, cfg[0]);
  endtask

  // One text byte transfer, with an optional idle burst ahead of it
  task automatic send_text_byte(input logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    do @(posedge clk_i); while (!text_ch.ready);
    items_sent++;
  endtask

  // Sender pause: every run of output bytes for the accepted text has arrived
  task automatic wait_results_drained();
    text_ch.valid <= 1'b0;
    while (runs_done != items_sent) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  // Mostly short well-formed lines; some blank lines and raw noise
  task automatic send_line();
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_text_byte(8'($urandom_range(0, 255)));
    end else if (kind < 22) begin
      repeat ($urandom_range(0, 2)) send_text_byte(pick_blank());
      send_text_byte(CH_NL);
    end else begin
      if ($urandom_range(0, 3) == 0) send_text_byte(pick_blank());
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_text_byte(8'($urandom_range(8'h21, 8'h7E)));
        else if (pick < 85) send_text_byte(8'($urandom_range(0, 255)));
        else send_text_byte(pick_blank());
      end
      send_text_byte(CH_NL);
    end
  endtask

  initial begin
    logic [2:0]  phase_cfg [9];
    int unsigned phase_end;
    phase_cfg = '{3'b111, 3'b000, 3'b101, 3'b010, 3'b110, 3'b001, 3'b011, 3'b100, 3'b111};

    rst_ni            <= 1'b0;
    psel_i            <= 1'b0;
    penable_i         <= 1'b0;
    pwrite_i          <= 1'b0;
    paddr_i           <= '0;
    pwdata_i          <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first byte is whitespace with numbering on, all display options on
    set_config(3'b111);
    send_text_byte(CH_SPACE);
    send_text_byte("A");
    send_text_byte(CH_TAB);
    send_text_byte(CH_NL);
    send_text_byte(CH_NL);
    send_text_byte(CH_SPACE);
    send_text_byte(CH_TAB);
    send_text_byte("B");
    send_text_byte(8'h00);
    send_text_byte(8'hFF);
    send_text_byte(CH_NL);
    wait_results_drained();
    // Plain pass-through of whitespace with numbering still on
    set_config(3'b100);
    send_text_byte(CH_NL);
    send_text_byte("z");
    send_text_byte(CH_SPACE);
    send_text_byte(CH_NL);
    wait_results_drained();
    // Numbering off: the pending number survives until numbering comes back
    set_config(3'b000);
    send_text_byte("q");
    send_text_byte(CH_NL);
    send_text_byte("r");
    send_text_byte(CH_SPACE);
    wait_results_drained();
    set_config(3'b100);
    send_text_byte("s");
    send_text_byte(CH_NL);
    wait_results_drained();

    // Random phases over all register settings; the last one runs without idling
    for (int p = 0; p < 9; p++) begin
      set_config(phase_cfg[p]);
      phase_end  = items_sent + (phase_cfg[p][2] ? 60 : 22);
      rx_idle_en = (p != 8) && ($urandom_range(0, 3) != 0);
      if (p == 0) rx_hold_req = 1'b1;
      if (p == 4) begin
        while (items_sent + 30 < phase_end) begin
          tx_idle_en = ($urandom_range(0, 3) != 0);
          send_line();
        end
        wait_results_drained();
      end
      while (items_sent < phase_end) begin
        tx_idle_en = (p != 8) && (p != 0) && ($urandom_range(0, 3) != 0);
        send_line();
      end
      wait_results_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_bytes != 0) $error("%0d expected output bytes never arrived", pending_bytes);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/tlnf_pkg.sv
rtl/text_in_if.sv
rtl/fmt_out_if.sv
rtl/tlnf_queue.sv
rtl/tlnf_front.sv
rtl/tlnf_back.sv
rtl/text_line_number_formatter_top.sv
tb/sv/text_line_number_formatter_checker.sv
tb/sv/text_line_number_formatter_top_tb.sv
